// ===== hdl/pidm_pkg.sv =====
// ----------------------------------------------------------------------------
// pidm_pkg
// Shared types and constants of the position PID motor drive.
// ----------------------------------------------------------------------------
package pidm_pkg;

	localparam int VEL_W  = 20;
	localparam int GAIN_W = 32;
	localparam int INT_W  = 40;
	localparam int DUTY_W = 16;
	localparam int MAG_W  = 15;
	localparam int PROD_W = 72;	// gain times integrator, full width
	localparam int CLIP_W = 63;	// product after clamp to +-2^61
	localparam int SUM_W  = 64;
	localparam int ILO_W  = 20;	// low slice of the integrator per partial product
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_STOP  = 2'd2;

	localparam logic signed [PROD_W-1:0] PROD_LIM = 72'sh0_2000_0000_0000_0000;
	localparam logic signed [DUTY_W-1:0] DUTY_MAX = 16'sd32767;

	typedef enum logic [2:0] {
		REG_TARGET_ANGLE    = 3'd0,
		REG_TARGET_VELOCITY = 3'd1,
		REG_GAIN_P          = 3'd2,
		REG_GAIN_D          = 3'd3,
		REG_GAIN_I          = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] target_angle;	// sign-extended from count width
		logic signed [VEL_W-1:0]  target_velocity;
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_d;
		logic signed [GAIN_W-1:0] gain_i;
	} cfg_t;

endpackage

// ===== hdl/pidm_apb_regs.sv =====
// ----------------------------------------------------------------------------
// pidm_apb_regs
// APB register file: targets and loop gains.
// ----------------------------------------------------------------------------
module pidm_apb_regs import pidm_pkg::*; #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en = psel & penable & pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_TARGET_ANGLE: begin
					cfg_q.target_angle <= DATA_W'($signed(pwdata[COUNT_WIDTH-1:0]));
				end
				REG_TARGET_VELOCITY: begin
					cfg_q.target_velocity <= pwdata[VEL_W-1:0];
				end
				REG_GAIN_P: cfg_q.gain_p <= pwdata;
				REG_GAIN_D: cfg_q.gain_d <= pwdata;
				REG_GAIN_I: cfg_q.gain_i <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TARGET_ANGLE:    prdata = cfg_q.target_angle;
			REG_TARGET_VELOCITY: prdata = DATA_W'(cfg_q.target_velocity);
			REG_GAIN_P:          prdata = cfg_q.gain_p;
			REG_GAIN_D:          prdata = cfg_q.gain_d;
			REG_GAIN_I:          prdata = cfg_q.gain_i;
			default:             prdata = '0;
		endcase
	end

endmodule

// ===== hdl/pid_position_motor_drive.sv =====
// ----------------------------------------------------------------------------
// pid_position_motor_drive
// Position PID loop with saturating integrator and H-bridge direction output.
//
//   channel   dir  handshake               contents
//   apb       in   psel/penable/pready     targets, gains (5 registers)
//   s_axis    in   tvalid/tready           tuser: mode; tdata: angle, velocity
//   m_axis    out  tvalid/tready           duty, magnitude, enables, saturated
//
// Five-stage pipeline, one item per cycle unless stalled. An item passes stages
// one to four into the output register, which can transfer in the cycle after
// it is loaded. The integrator is read and written in stage one.
// Reset clears registers, integrator and all stage valids.
// A stalled output fills the empty stages first; s_axis_tready falls only
// when every stage holds an item.
// ----------------------------------------------------------------------------
module pid_position_motor_drive import pidm_pkg::*; #(
	parameter int COUNT_WIDTH    = 24,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [ADDR_W-1:0]                       paddr,
	input  logic [DATA_W-1:0]                       pwdata,
	output logic [DATA_W-1:0]                       prdata,
	output logic                                    pready,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	// angle_count[COUNT_WIDTH-1:0], velocity_count above, zero pad
	input  logic [((COUNT_WIDTH + 27) / 8) * 8 - 1:0] s_axis_tdata,
	// mode[1:0]
	input  logic [1:0]                              s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	// drive_signed[15:0], duty_magnitude[30:16], forward_enable[31],
	// reverse_enable[32], saturated[33], zero pad
	output logic [39:0]                             m_axis_tdata
);

	localparam int AW = COUNT_WIDTH + 1;	// angle error width
	localparam int VW = VEL_W + 1;		// velocity error width

	cfg_t cfg;

	pidm_apb_regs #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// stage flow control
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic free_out, free_s4, free_s3, free_s2, free_s1;

	assign free_out      = ~out_valid_q | m_axis_tready;
	assign free_s4       = ~v_s4 | free_out;
	assign free_s3       = ~v_s3 | free_s4;
	assign free_s2       = ~v_s2 | free_s3;
	assign free_s1       = ~v_s1 | free_s2;
	assign s_axis_tready = free_s1;

	// stage 1: input register
	logic [1:0]                    mode_s1;
	logic signed [COUNT_WIDTH-1:0] angle_s1;
	logic signed [VEL_W-1:0]       vel_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (free_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s1) begin
			mode_s1  <= s_axis_tuser;
			angle_s1 <= s_axis_tdata[COUNT_WIDTH-1:0];
			vel_s1   <= s_axis_tdata[COUNT_WIDTH+VEL_W-1:COUNT_WIDTH];
		end
	end

	// errors and integrator update
	logic signed [COUNT_WIDTH-1:0] tgt_angle;
	logic signed [AW-1:0]          aerr;
	logic signed [VW-1:0]          verr;
	logic signed [INT_W-1:0]       integ_q;
	logic signed [INT_W-1:0]       integ_base;
	logic signed [INT_W:0]         acc_sum;
	logic signed [INT_W-1:0]       acc_sat;
	logic                          acc_clip;
	logic                          stop_s1;

	assign tgt_angle  = cfg.target_angle[COUNT_WIDTH-1:0];
	assign aerr       = AW'(angle_s1) - AW'(tgt_angle);
	assign verr       = VW'(vel_s1) - VW'(cfg.target_velocity);
	assign stop_s1    = (mode_s1 >= MODE_STOP);
	assign integ_base = (mode_s1 == MODE_START) ? '0 : integ_q;
	assign acc_sum    = (INT_W+1)'(integ_base) + (INT_W+1)'(aerr);
	assign acc_clip   = acc_sum[INT_W] ^ acc_sum[INT_W-1];

	always_comb begin
		if (!acc_clip) begin
			acc_sat = acc_sum[INT_W-1:0];
		end else if (acc_sum[INT_W]) begin
			acc_sat = {1'b1, {(INT_W-1){1'b0}}};
		end else begin
			acc_sat = {1'b0, {(INT_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (v_s1 && free_s2 && !stop_s1) begin
			integ_q <= acc_sat;
		end
	end

	// stage 2: errors and integral
	logic signed [AW-1:0]    aerr_s2;
	logic signed [VW-1:0]    verr_s2;
	logic signed [INT_W-1:0] acc_s2;
	logic                    sat_s2, stop_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (free_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s2) begin
			aerr_s2 <= aerr;
			verr_s2 <= verr;
			acc_s2  <= acc_sat;
			sat_s2  <= acc_clip;
			stop_s2 <= stop_s1;
		end
	end

	// products; the integral term is split in two partial products
	logic signed [GAIN_W+AW-1:0]              prod_p;
	logic signed [GAIN_W+VW-1:0]              prod_d;
	logic signed [GAIN_W+ILO_W:0]             prod_ilo;
	logic signed [GAIN_W+INT_W-ILO_W-1:0]     prod_ihi;
	logic signed [ILO_W:0]                    acc_lo;
	logic signed [INT_W-ILO_W-1:0]            acc_hi;

	assign acc_lo   = {1'b0, acc_s2[ILO_W-1:0]};
	assign acc_hi   = acc_s2[INT_W-1:ILO_W];
	assign prod_p   = cfg.gain_p * aerr_s2;
	assign prod_d   = cfg.gain_d * verr_s2;
	assign prod_ilo = cfg.gain_i * acc_lo;
	assign prod_ihi = cfg.gain_i * acc_hi;

	// stage 3: partial products
	logic signed [GAIN_W+AW-1:0]          prod_p_s3;
	logic signed [GAIN_W+VW-1:0]          prod_d_s3;
	logic signed [GAIN_W+ILO_W:0]         prod_ilo_s3;
	logic signed [GAIN_W+INT_W-ILO_W-1:0] prod_ihi_s3;
	logic                                 sat_s3, stop_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (free_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s3) begin
			prod_p_s3   <= prod_p;
			prod_d_s3   <= prod_d;
			prod_ilo_s3 <= prod_ilo;
			prod_ihi_s3 <= prod_ihi;
			sat_s3      <= sat_s2;
			stop_s3     <= stop_s2;
		end
	end

	function automatic logic signed [CLIP_W-1:0] clip_prod(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] r;
		begin
			if (p > PROD_LIM) begin
				r = PROD_LIM;
			end else if (p < -PROD_LIM) begin
				r = -PROD_LIM;
			end else begin
				r = p;
			end
			clip_prod = r[CLIP_W-1:0];
		end
	endfunction

	logic signed [PROD_W-1:0] prod_i;
	logic signed [CLIP_W-1:0] clip_p, clip_d, clip_i;

	assign prod_i = (PROD_W'(prod_ihi_s3) <<< ILO_W) + PROD_W'(prod_ilo_s3);
	assign clip_p = clip_prod(PROD_W'(prod_p_s3));
	assign clip_d = clip_prod(PROD_W'(prod_d_s3));
	assign clip_i = clip_prod(prod_i);

	// stage 4: clamped terms
	logic signed [CLIP_W-1:0] clip_p_s4, clip_d_s4, clip_i_s4;
	logic                     sat_s4, stop_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (free_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s4) begin
			clip_p_s4 <= clip_p;
			clip_d_s4 <= clip_d;
			clip_i_s4 <= clip_i;
			sat_s4    <= sat_s3;
			stop_s4   <= stop_s3;
		end
	end

	// sum, scale, duty clamp and bridge decode
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  scaled;
	logic signed [DUTY_W-1:0] duty;
	logic                     duty_clip;
	logic [DUTY_W-1:0]        duty_abs;

	assign sum    = SUM_W'(clip_p_s4) + SUM_W'(clip_d_s4) + SUM_W'(clip_i_s4);
	assign scaled = sum >>> GAIN_FRAC_BITS;

	always_comb begin
		if (scaled > SUM_W'(DUTY_MAX)) begin
			duty      = DUTY_MAX;
			duty_clip = 1'b1;
		end else if (scaled < -SUM_W'(DUTY_MAX)) begin
			duty      = -DUTY_MAX;
			duty_clip = 1'b1;
		end else begin
			duty      = scaled[DUTY_W-1:0];
			duty_clip = 1'b0;
		end
	end

	assign duty_abs = duty[DUTY_W-1] ? DUTY_W'(-duty) : duty;

	// output register
	logic signed [DUTY_W-1:0] drive_q;
	logic [MAG_W-1:0]         mag_q;
	logic                     fwd_q, rev_q, sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (free_out) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (free_out) begin
			if (stop_s4) begin
				drive_q <= '0;
				mag_q   <= '0;
				fwd_q   <= 1'b0;
				rev_q   <= 1'b0;
				sat_q   <= 1'b0;
			end else begin
				drive_q <= duty;
				mag_q   <= duty_abs[MAG_W-1:0];
				fwd_q   <= ~duty[DUTY_W-1] & (duty != '0);
				rev_q   <= duty[DUTY_W-1];
				sat_q   <= sat_s4 | duty_clip;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, sat_q, rev_q, fwd_q, mag_q, drive_q};

endmodule
